### rtl/tta_pkg.sv
// ----------------------------------------------------------------------------
// tta_pkg: shared types and constants of the timer table
// Entry layout, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package tta_pkg;

  // Default table depth.
  localparam int unsigned MaxTimersDef = 16;

  // Field widths.
  localparam int unsigned IdW   = 16;
  localparam int unsigned IvalW = 64;

  // Minimum of an empty table.
  localparam logic [IvalW-1:0] InfTime = '1;

  // One stored timer.
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [IvalW-1:0] ival;
  } entry_t;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_DONE,
    S_REM_SCAN,
    S_REM_MOVE,
    S_OUT
  } state_e;

endpackage

### rtl/timer_table_add_remove.sv
// ----------------------------------------------------------------------------
// timer_table_add_remove: timer table with unique ids and minimum tracking
// Adds and removes timers in a packed table held in a memory with one read
// port and one write port.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o   | command_i, timer_id_i, interval_i
//  out     | output    | out_valid_o / out_ready_i | status_o, lowest_ival_o,
//          |           |                           | timer_count_o
//
//  One beat is worked on at a time. An add scans the stored entries for its id
//  before it appends; a remove scans for the id, fills its slot with the last
//  entry and rebuilds the minimum; the memory read port reads one entry per cycle.
//  Reset clears the count and sets the minimum to all ones; the memory is not
//  cleared, since only slots below the count are read.
//  A result waits in its register while out_ready_i is low; no new beat is
//  accepted until it has been taken.
// ----------------------------------------------------------------------------
module timer_table_add_remove
  import tta_pkg::*;
#(
  parameter int unsigned MAX_TIMERS = MaxTimersDef,
  parameter int unsigned CntW       = $clog2(MAX_TIMERS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [IdW-1:0]   timer_id_i,
  input  logic [IvalW-1:0] interval_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [IvalW-1:0] lowest_ival_o,
  output logic [CntW-1:0]  timer_count_o
);

  localparam int unsigned AddrW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  state_e           state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [IvalW-1:0] ival_q, ival_d;
  status_e          status_q, status_d;
  logic [IvalW-1:0] min_q, min_d;
  logic [CntW-1:0]  count_q, count_d;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t           wr_data;
  entry_t           rd_data;

  logic [CntW-1:0]  last_idx;
  logic             at_last;
  logic             hit;
  logic             full;
  logic             is_remove;

  // Entry storage.
  tta_mem #(
    .Depth (MAX_TIMERS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Scan conditions on the entry in the read register.
  assign last_idx  = count_q - CntW'(1);
  assign at_last   = (CntW'(idx_q) == last_idx);
  assign hit       = (rd_data.id == id_q);
  assign full      = (count_q == CntW'(MAX_TIMERS));
  assign is_remove = (cmd_e'(command_i) == CMD_REMOVE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (is_remove) begin
            state_d = (count_q == '0) ? S_OUT : S_REM_SCAN;
          end else begin
            state_d = (count_q == '0) ? S_ADD_DONE : S_ADD_SCAN;
          end
        end
      end
      S_ADD_SCAN: begin
        if (hit) begin
          state_d = S_OUT;
        end else if (at_last) begin
          state_d = S_ADD_DONE;
        end
      end
      S_ADD_DONE: begin
        state_d = S_OUT;
      end
      S_REM_SCAN: begin
        if (hit) begin
          state_d = S_REM_MOVE;
        end else if (at_last) begin
          state_d = S_OUT;
        end
      end
      S_REM_MOVE: begin
        // The moved entry stays in the read register and is checked next.
        state_d = at_last ? S_OUT : S_REM_SCAN;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    idx_d    = idx_q;
    id_d     = id_q;
    ival_d   = ival_q;
    status_d = status_q;
    min_d    = min_q;
    count_d  = count_q;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_data  = rd_data;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          id_d    = timer_id_i;
          ival_d  = interval_i;
          idx_d   = '0;
          rd_en   = 1'b1;
          rd_addr = '0;
          if (is_remove) begin
            min_d    = InfTime;
            status_d = ST_NOTFOUND;
          end else begin
            status_d = ST_OK;
          end
        end
      end
      S_ADD_SCAN: begin
        if (hit) begin
          status_d = ST_EXISTS;
        end else if (!at_last) begin
          idx_d   = idx_q + AddrW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_q + AddrW'(1);
        end
      end
      S_ADD_DONE: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = count_q[AddrW-1:0];
          wr_data = '{id: id_q, ival: ival_q};
          count_d = count_q + CntW'(1);
          if (ival_q < min_q) begin
            min_d = ival_q;
          end
        end
      end
      S_REM_SCAN: begin
        if (hit) begin
          // Fetch the last entry to fill this slot.
          status_d = ST_OK;
          rd_en    = 1'b1;
          rd_addr  = last_idx[AddrW-1:0];
        end else begin
          if (rd_data.ival < min_q) begin
            min_d = rd_data.ival;
          end
          if (!at_last) begin
            idx_d   = idx_q + AddrW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_q + AddrW'(1);
          end
        end
      end
      S_REM_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data;
        count_d = last_idx;
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Control state and table summary.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      min_q   <= InfTime;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      min_q   <= min_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    id_q     <= id_d;
    ival_q   <= ival_d;
    status_q <= status_d;
  end

  // Ports.
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign status_o      = status_q;
  assign lowest_ival_o = min_q;
  assign timer_count_o = count_q;

endmodule

### rtl/tta_mem.sv
// ----------------------------------------------------------------------------
// tta_mem: entry storage of the timer table
// One write port and one read port; the read data is registered and holds
// its value in cycles without a read.
// ----------------------------------------------------------------------------
module tta_mem
  import tta_pkg::*;
#(
  parameter int unsigned Depth = MaxTimersDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
